[rtl/striped_read_splitter_macros.svh]
// Assertion macros shared by the checker of the striped read splitter.
// Depends on nothing; every macro expects a clock named clk and a reset named rst.
`ifndef STRIPED_READ_SPLITTER_MACROS_SVH
`define STRIPED_READ_SPLITTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("striped read splitter: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("striped read splitter: next-cycle check failed");

`endif

[rtl/srs_pkg.sv]
// Package of the striped read splitter: field widths, defaults, queue entry and FSM type.
// Used by every module of the block; depends on nothing.
package srs_pkg;

  localparam int OFFSET_W = 48;
  localparam int LEN_W    = 32;
  localparam int SIZE_W   = 32;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 144;

  localparam logic [SIZE_W-1:0] OBJECT_SIZE_RESET = 32'd4194304;

  localparam int MAX_CHUNKS_DEFAULT  = 64;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Status codes of a result.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_TOO_MANY = 1'b1;

  // One classified request as it passes from the front part to the back part.
  typedef struct packed {
    logic [OFFSET_W-1:0] index;
    logic [SIZE_W-1:0]   start;
    logic [LEN_W-1:0]    length;
    logic                too_many;
  } srs_entry_t;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_DIV,
    FRONT_PUSH
  } front_state_t;

endpackage

[rtl/srs_queue.sv]
// Short register queue between the front and back parts of the splitter.
// Depends on srs_pkg for the entry type.
module srs_queue
  import srs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  srs_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output srs_entry_t pop_entry,
  output logic       empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  srs_entry_t             slots [DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;
  logic                   do_push;
  logic                   do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

[rtl/srs_front.sv]
// Front part of the splitter: accepts requests, divides the offset by the object size
// one quotient bit a cycle and checks the span. Depends on srs_pkg.
module srs_front
  import srs_pkg::*;
#(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SIZE_W:0]      size,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic [OFFSET_W-1:0]  req_offset,
  input  logic [LEN_W-1:0]     req_length,
  output logic                 push,
  output srs_entry_t           push_entry,
  input  logic                 q_full
);

  localparam int CNT_W   = $clog2(OFFSET_W);
  localparam int LIMIT_W = $clog2(MAX_CHUNKS + 1) + SIZE_W + 1;
  localparam int SPAN_W  = SIZE_W + 2;

  front_state_t         state;
  front_state_t         state_next;
  logic [CNT_W-1:0]     div_cnt;
  logic [OFFSET_W-1:0]  quo;
  logic [SIZE_W:0]      rem;
  logic [LEN_W-1:0]     len;

  logic [SIZE_W+1:0]    rem_sh;
  logic                 rem_ge;
  logic [SIZE_W+1:0]    rem_sub;
  logic [SPAN_W-1:0]    span;
  logic [LIMIT_W-1:0]   limit;
  logic                 accept;

  // One restoring division step.
  always_comb begin
    rem_sh  = {rem, quo[OFFSET_W-1]};
    rem_ge  = (rem_sh >= {1'b0, size});
    rem_sub = rem_sh - {1'b0, size};
  end

  // Span check: the request needs more than MAX_CHUNKS objects exactly when
  // start plus length exceeds MAX_CHUNKS whole objects.
  always_comb begin
    span  = SPAN_W'(rem) + SPAN_W'(len);
    limit = LIMIT_W'(MAX_CHUNKS) * LIMIT_W'(size);
  end

  assign accept = req_valid && req_ready;

  always_comb begin
    push_entry.index    = quo;
    push_entry.start    = rem[SIZE_W-1:0];
    push_entry.length   = len;
    push_entry.too_many = (LIMIT_W'(span) > limit);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FRONT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    push       = 1'b0;
    unique case (state)
      FRONT_IDLE: begin
        req_ready = 1'b1;
        if (req_valid && (req_length != '0)) begin
          state_next = FRONT_DIV;
        end
      end
      FRONT_DIV: begin
        if (div_cnt == CNT_W'(OFFSET_W - 1)) begin
          state_next = FRONT_PUSH;
        end
      end
      FRONT_PUSH: begin
        if (!q_full) begin
          push       = 1'b1;
          state_next = FRONT_IDLE;
        end
      end
      default: state_next = FRONT_IDLE;
    endcase
  end

  // Division datapath; a zero-length request is taken and dropped.
  always_ff @(posedge clk) begin
    if (accept) begin
      quo     <= req_offset;
      rem     <= '0;
      len     <= req_length;
      div_cnt <= '0;
    end else if (state == FRONT_DIV) begin
      quo     <= {quo[OFFSET_W-2:0], rem_ge};
      rem     <= rem_ge ? rem_sub[SIZE_W:0] : rem_sh[SIZE_W:0];
      div_cnt <= div_cnt + 1'b1;
    end
  end

endmodule

[rtl/srs_back.sv]
// Back part of the splitter: walks one classified request object by object and delivers
// a chunk a cycle through a registered output while it is not stalled. Depends on srs_pkg.
module srs_back
  import srs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [SIZE_W:0]       size,
  input  logic                  q_empty,
  input  srs_entry_t            q_entry,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [0:0]            m_tuser,
  output logic                  m_tlast
);

  logic                 active;
  logic [OFFSET_W-1:0]  cur_index;
  logic [SIZE_W-1:0]    cur_start;
  logic [LEN_W-1:0]     cur_rem;
  logic [LEN_W-1:0]     cur_buf;
  logic                 cur_err;

  logic [OFFSET_W-1:0]  out_index;
  logic [SIZE_W-1:0]    out_off;
  logic [LEN_W-1:0]     out_len;
  logic [LEN_W-1:0]     out_buf;
  logic                 out_status;
  logic                 out_last;

  logic [SIZE_W:0]      room;
  logic [LEN_W-1:0]     take;
  logic [LEN_W-1:0]     rem_after;
  logic                 advance;

  // Chunk length is the smaller of the bytes left and the room in the object.
  always_comb begin
    room      = size - {1'b0, cur_start};
    take      = ({1'b0, cur_rem} < room) ? cur_rem : room[LEN_W-1:0];
    rem_after = cur_rem - take;
    advance   = active && (!m_tvalid || m_tready);
    pop       = !active && !q_empty;
  end

  // Control: current request and output register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
      end else if (advance) begin
        active <= !(cur_err || (rem_after == '0));
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Walk state and result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_index <= q_entry.index;
      cur_start <= q_entry.start;
      cur_rem   <= q_entry.length;
      cur_buf   <= '0;
      cur_err   <= q_entry.too_many;
    end else if (advance) begin
      out_index <= cur_index;
      out_off   <= cur_start;
      if (cur_err) begin
        out_len    <= '0;
        out_buf    <= '0;
        out_status <= STATUS_TOO_MANY;
        out_last   <= 1'b1;
      end else begin
        out_len    <= take;
        out_buf    <= cur_buf;
        out_status <= STATUS_OK;
        out_last   <= (rem_after == '0);
      end
      cur_index <= cur_index + 1'b1;
      cur_start <= '0;
      cur_rem   <= rem_after;
      cur_buf   <= cur_buf + take;
    end
  end

  assign m_tdata = {out_buf, out_len, out_off, out_index};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

endmodule

[rtl/striped_read_splitter.sv]
// Top level of the striped read splitter: object size register, front part, queue, back part.
// Depends on srs_pkg, srs_front, srs_queue and srs_back.
//
//   Channel   Direction  Handshake           Contents
//   s_*       in         s_tvalid/s_tready   byte_offset, request_length
//   m_*       out        m_tvalid/m_tready   object_index .. buffer_offset, status, last_chunk
//   cfg_*     in         cfg_wr_en           object size in bytes
//
// A request with non-zero length occupies the front part while it is accepted, while its offset
// is divided bit-serially by the object size and until it is queued. The back part then delivers
// one chunk a cycle, unless the output stalls, while the front divides the next request.
// Zero-length requests are taken and give nothing.
// Reset is synchronous; it empties the queue and sets the object size to 4194304 bytes.
// A stall on the output holds the result register and, once the queue fills, the input.
module striped_read_splitter
  import srs_pkg::*;
#(
  parameter int MAX_CHUNKS  = MAX_CHUNKS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // byte_offset[47:0], request_length[79:48]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // object_index[47:0], object_offset[79:48],
                                           // chunk_length[111:80], buffer_offset[143:112]
  output logic [0:0]            m_tuser,   // status[0]
  output logic                  m_tlast,   // last_chunk
  input  logic                  cfg_wr_en,
  input  logic [SIZE_W-1:0]     cfg_wr_data // object size in bytes
);

  logic [SIZE_W-1:0] obj_bytes;
  logic [SIZE_W:0]   size;
  logic              push;
  srs_entry_t        push_entry;
  logic              q_full;
  logic              pop;
  srs_entry_t        pop_entry;
  logic              q_empty;

  // Object size register; zero stands for 2^32 bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      obj_bytes <= OBJECT_SIZE_RESET;
    end else if (cfg_wr_en) begin
      obj_bytes <= cfg_wr_data;
    end
  end

  assign size = (obj_bytes == '0) ? {1'b1, {SIZE_W{1'b0}}} : {1'b0, obj_bytes};

  srs_front #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .size       (size),
    .req_valid  (s_tvalid),
    .req_ready  (s_tready),
    .req_offset (s_tdata[OFFSET_W-1:0]),
    .req_length (s_tdata[OFFSET_W+LEN_W-1:OFFSET_W]),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  srs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  srs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .size     (size),
    .q_empty  (q_empty),
    .q_entry  (pop_entry),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[rtl/srs_checker.sv]
// Port-level checks of the striped read splitter, bound to the top level.
// Depends on srs_pkg and striped_read_splitter_macros.svh.
`include "striped_read_splitter_macros.svh"

module srs_checker
  import srs_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [0:0]            m_tuser,
  input logic                  m_tlast
);

  // A rejected request gives a single result that closes it.
  `SRS_ASSERT_NOW(a_reject_is_last, m_tvalid && m_tuser[0], m_tlast)

  // A rejected request reports no length and no buffer position.
  `SRS_ASSERT_NOW(a_reject_empty, m_tvalid && m_tuser[0], m_tdata[143:80] == '0)

  // A valid chunk always carries at least one byte.
  `SRS_ASSERT_NOW(a_chunk_nonzero, m_tvalid && !m_tuser[0], m_tdata[111:80] != '0)

  // A request of non-zero length keeps the input closed while it is divided.
  `SRS_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready && (s_tdata[79:48] != '0), !s_tready)

  // A stalled result holds.
  `SRS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind striped_read_splitter srs_checker u_srs_checker (.*);

[tb/sv/tb_top.sv]
// Self-checking testbench of the striped read splitter: stream drivers and a chunk scoreboard.
// Depends on srs_pkg and the striped_read_splitter RTL; needs no files or arguments.
`timescale 1ns / 100ps

module tb_top
  import srs_pkg::*;
();

  localparam int MAX_SPLIT = MAX_CHUNKS_DEFAULT;
  localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] MAX_LEN = 64'hFFFF_FFFF;

  // One chunk as the block should deliver it.
  typedef struct packed {
    logic [47:0] index;
    logic [31:0] offset;
    logic [31:0] length;
    logic [31:0] bufpos;
    logic        status;
    logic        last;
  } chunk_t;

  // Predicts the chunks of each accepted request and compares them with the output.
  class chunk_scoreboard;
    chunk_t      pending_chunks[$];
    logic [31:0] obj_bytes;
    int          errors;

    function new();
      obj_bytes = OBJECT_SIZE_RESET;
      errors    = 0;
    endfunction

    function void set_obj_bytes(logic [31:0] value);
      obj_bytes = value;
    endfunction

    // Object size as a divisor: zero stands for 2^32 bytes.
    function logic [63:0] span();
      return (obj_bytes == 0) ? 64'h1_0000_0000 : {32'd0, obj_bytes};
    endfunction

    // Works out the chunks of one accepted request.
    function void split_request(logic [47:0] byte_off, logic [31:0] req_len);
      logic [63:0] sz, idx, start, remaining, bufpos, room, part, count;
      chunk_t      c;
      if (req_len == 0) return;
      sz    = span();
      idx   = {16'd0, byte_off} / sz;
      start = {16'd0, byte_off} % sz;
      count = (start + {32'd0, req_len} + sz - 1) / sz;
      if (count > MAX_SPLIT) begin
        c = '{index: idx[47:0], offset: start[31:0], length: '0, bufpos: '0,
              status: STATUS_TOO_MANY, last: 1'b1};
        pending_chunks.push_back(c);
        return;
      end
      remaining = {32'd0, req_len};
      bufpos    = 0;
      while (remaining > 0) begin
        room = sz - start;
        part = (remaining < room) ? remaining : room;
        remaining -= part;
        c = '{index: idx[47:0], offset: start[31:0], length: part[31:0],
              bufpos: bufpos[31:0], status: STATUS_OK, last: remaining == 0};
        pending_chunks.push_back(c);
        bufpos += part;
        idx   = (idx + 1) & MASK48;
        start = 0;
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
    endfunction

    // Checks one accepted result against the oldest prediction.
    function void check_result(logic [OUT_DATA_W-1:0] data, logic status, logic last);
      chunk_t c;
      if (pending_chunks.size() == 0) begin
        errors++;
        $display("%0t: unexpected chunk, expected none got %h", $time, data);
        return;
      end
      c = pending_chunks.pop_front();
      compare_field("object_index", c.index, data[47:0]);
      compare_field("object_offset", c.offset, data[79:48]);
      compare_field("chunk_length", c.length, data[111:80]);
      compare_field("buffer_offset", c.bufpos, data[143:112]);
      compare_field("status", c.status, status);
      compare_field("last_chunk", c.last, last);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;
  logic                  m_tlast;
  logic                  cfg_wr_en;
  logic [SIZE_W-1:0]     cfg_wr_data;

  chunk_scoreboard scoreboard;
  bit              steady;

  striped_read_splitter dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

  // Offers one request after a random gap and waits until it is taken.
  // Ready is sampled at the falling edge, where it has settled for the coming rising edge.
  task automatic send_request(input logic [47:0] byte_off, input logic [31:0] req_len);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {req_len, byte_off};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    scoreboard.split_request(byte_off, req_len);
  endtask

  // Waits until every chunk has arrived and the front part has gone quiet.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (scoreboard.pending_chunks.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Writes the object size while the block is idle.
  task automatic set_size(input logic [31:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scoreboard.set_obj_bytes(value);
  endtask

  // Random request, mostly within the chunk limit, sometimes near an object edge.
  task automatic send_random();
    logic [63:0] sz, limit, off, len;
    int          mode, k;
    sz   = scoreboard.span();
    mode = $urandom_range(0, 99);
    off  = {$urandom, $urandom} & MASK48;
    if ($urandom_range(0, 2) == 0)
      off = (off - off % sz + sz - $urandom_range(1, 3)) & MASK48;
    if (mode < 5) begin
      len = 0;
    end else if (mode < 20) begin
      len = {32'd0, $urandom};
    end else begin
      k     = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 6);
      limit = sz * k;
      if (limit > MAX_LEN) limit = MAX_LEN;
      len = 1 + ({$urandom, $urandom} % limit);
    end
    send_request(off[47:0], len[31:0]);
  endtask

  task automatic random_phase(input int count);
    repeat (count) send_random();
  endtask

  // Result side: random stalls, one acceptance per iteration.
  // Valid and data are sampled at the falling edge before the accepting rising edge.
  initial begin
    int                    stall;
    logic [OUT_DATA_W-1:0] got_data;
    logic                  got_status;
    logic                  got_last;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        m_tready <= 1'b0;
        @(posedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
      while (!m_tvalid) @(negedge clk);
      got_data   = m_tdata;
      got_status = m_tuser[0];
      got_last   = m_tlast;
      @(posedge clk);
      scoreboard.check_result(got_data, got_status, got_last);
    end
  end

  // Stimulus and end of run.
  initial begin
    scoreboard  = new();
    steady      = 1'b0;
    rst         <= 1'b1;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset object size of 4 MiB: edges of the fields and of the chunk limit.
    send_request(48'd0, 32'd0);
    send_request(48'd0, 32'd1);
    send_request(48'hFFFF_FFFF_FFFF, 32'd1);
    send_request(48'h3F_FFFF, 32'd2);
    send_request(48'd0, 32'h1000_0000);
    send_request(48'd1, 32'h0FFF_FFFF);
    send_request(48'd1, 32'h1000_0000);
    send_request(48'd0, 32'h1000_0001);
    send_request(48'd123, 32'hFFFF_FFFF);
    send_request(48'h140_0000, 32'h40_0000);
    send_request(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(40);

    // One-byte objects: the index wraps past the top of its width.
    set_size(32'd1);
    steady = 1'b1;
    send_request(48'hFFFF_FFFF_FFFF, 32'd2);
    send_request(48'hFFFF_FFFF_FFFE, 32'd64);
    send_request(48'd0, 32'd65);
    send_request(48'd5, 32'd0);
    random_phase(40);

    // Zero stands for objects of 2^32 bytes.
    set_size(32'd0);
    steady = 1'b0;
    send_request(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_request(48'd0, 32'hFFFF_FFFF);
    send_request(48'h0000_FFFF_FFFF, 32'd1);
    random_phase(40);

    set_size(32'hFFFF_FFFF);
    steady = 1'b1;
    send_request(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(40);

    set_size(32'd4096);
    steady = 1'b0;
    random_phase(20);
    // Let everything drain mid-phase before carrying on.
    drain();
    random_phase(20);

    set_size(32'd7);
    random_phase(40);

    set_size($urandom_range(2, 1 << 20));
    random_phase(40);

    drain();
    if (scoreboard.errors == 0 && scoreboard.pending_chunks.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/srs_pkg.sv
rtl/srs_queue.sv
rtl/srs_front.sv
rtl/srs_back.sv
rtl/striped_read_splitter.sv
rtl/srs_checker.sv
tb/sv/tb_top.sv
